>>> hw/rtl/cpb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpb_pkg: shared types and constants of the column-post patch blitter
// Command codes, coordinate widths and the request record that travels from
// the front end to the drawing back end.
// ----------------------------------------------------------------------------
package cpb_pkg;

	localparam int unsigned PALETTE_DEPTH = 256;
	localparam int unsigned PAL_AW        = $clog2(PALETTE_DEPTH);
	localparam int unsigned COORD_BITS    = 12;
	// signed screen coordinate: patch coordinate plus a 13-bit signed origin
	localparam int unsigned SCR_BITS      = (COORD_BITS + 2 > 14) ? COORD_BITS + 2 : 14;
	localparam int unsigned DIM_BITS      = 13;
	localparam int unsigned COLOR_BITS    = 24;
	localparam int unsigned ADDR_BITS     = 24;
	localparam int unsigned QUEUE_DEPTH   = 4;
	localparam int unsigned QUEUE_AW      = $clog2(QUEUE_DEPTH);

	localparam logic [7:0] POST_TERMINATOR = 8'hff;

	typedef enum logic [1:0] {
		CMD_PALETTE = 2'd0,
		CMD_COLUMN  = 2'd1,
		CMD_HEADER  = 2'd2,
		CMD_PIXEL   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		REG_WIDTH    = 2'd0,
		REG_HEIGHT   = 2'd1,
		REG_ORIGIN_X = 2'd2,
		REG_ORIGIN_Y = 2'd3
	} reg_idx_t;

	// One queued request: a palette write or a visible pixel to draw.
	typedef struct packed {
		logic                  is_write;
		logic [7:0]            index;
		logic                  index_ok;
		logic [COLOR_BITS-1:0] rgb;
		logic [DIM_BITS-1:0]   row;
		logic [DIM_BITS-1:0]   col;
	} req_t;

endpackage
`default_nettype wire

>>> hw/rtl/cpb_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpb_if: channel interfaces of the column-post patch blitter
// Command channel, pixel channel and configuration write channel, each with
// valid/ready handshake.
// ----------------------------------------------------------------------------
interface cpb_cmd_if;
	import cpb_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [1:0]             cmd;
	logic [COORD_BITS-1:0]  column_x;
	logic [7:0]             top_delta;
	logic [7:0]             run_length;
	logic [7:0]             pixel_index;
	logic [COLOR_BITS-1:0]  palette_color;

	modport source (output valid, cmd, column_x, top_delta, run_length, pixel_index,
		palette_color, input ready);
	modport sink (input valid, cmd, column_x, top_delta, run_length, pixel_index,
		palette_color, output ready);
endinterface

interface cpb_pixel_if;
	import cpb_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [ADDR_BITS-1:0]  pixel_address;
	logic [COLOR_BITS-1:0] pixel_rgb;

	modport source (output valid, pixel_address, pixel_rgb, input ready);
	modport sink (input valid, pixel_address, pixel_rgb, output ready);
endinterface

interface cpb_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [12:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/cpb_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpb_front: command decode and clipping
// Holds the configuration and the column/post walk state, and turns each
// accepted command into at most one request for the back end.
// ----------------------------------------------------------------------------
module cpb_front (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	cpb_cmd_if.sink                           items,
	cpb_cfg_if.sink                           cfg,
	input  wire logic                         queue_full,
	output logic                              push,
	output cpb_pkg::req_t                     push_req,
	output logic [cpb_pkg::DIM_BITS-1:0]      canvas_width
);
	import cpb_pkg::*;

	logic [DIM_BITS-1:0]        width_q;
	logic [DIM_BITS-1:0]        height_q;
	logic signed [DIM_BITS-1:0] origin_x_q;
	logic signed [DIM_BITS-1:0] origin_y_q;

	logic signed [SCR_BITS-1:0] column_q;
	logic                       visible_q;
	logic signed [SCR_BITS-1:0] row_q;
	logic [7:0]                 left_q;

	logic                       accept;
	cmd_t                       cmd;
	logic signed [SCR_BITS-1:0] column_new;
	logic                       column_vis_new;
	logic                       row_vis;
	logic                       index_ok;

	assign cfg.ready    = 1'b1;
	assign items.ready  = !queue_full;
	assign accept       = items.valid && items.ready;
	assign cmd          = cmd_t'(items.cmd);
	assign canvas_width = width_q;

	assign column_new = SCR_BITS'($signed({1'b0, items.column_x})) + SCR_BITS'(origin_x_q);
	assign column_vis_new = !column_new[SCR_BITS-1] &&
		(column_new < SCR_BITS'($signed({1'b0, width_q})));
	assign row_vis = !row_q[SCR_BITS-1] && (row_q < SCR_BITS'($signed({1'b0, height_q})));
	assign index_ok = ({1'b0, items.pixel_index} < 9'(PALETTE_DEPTH));

	always_comb begin
		push_req.is_write = (cmd == CMD_PALETTE);
		push_req.index    = items.pixel_index;
		push_req.index_ok = index_ok;
		push_req.rgb      = items.palette_color;
		push_req.row      = DIM_BITS'(row_q);
		push_req.col      = DIM_BITS'(column_q);
		push = 1'b0;
		if (accept) begin
			unique case (cmd)
				CMD_PALETTE: push = index_ok;
				CMD_PIXEL:   push = (left_q != 8'd0) && visible_q && row_vis;
				CMD_COLUMN,
				CMD_HEADER:  push = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= DIM_BITS'(64);
			height_q   <= DIM_BITS'(64);
			origin_x_q <= '0;
			origin_y_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (reg_idx_t'(cfg.index))
				REG_WIDTH:    width_q    <= cfg.data;
				REG_HEIGHT:   height_q   <= cfg.data;
				REG_ORIGIN_X: origin_x_q <= cfg.data;
				REG_ORIGIN_Y: origin_y_q <= cfg.data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q  <= '0;
			visible_q <= 1'b0;
			row_q     <= '0;
			left_q    <= '0;
		end else if (accept) begin
			unique case (cmd)
				CMD_PALETTE: ;
				CMD_COLUMN: begin
					// abandon any post in progress
					column_q  <= column_new;
					visible_q <= column_vis_new;
					left_q    <= '0;
				end
				CMD_HEADER: begin
					if (items.top_delta == POST_TERMINATOR) begin
						left_q <= '0;
					end else begin
						row_q  <= SCR_BITS'($signed({1'b0, items.top_delta})) +
							SCR_BITS'(origin_y_q);
						left_q <= items.run_length;
					end
				end
				CMD_PIXEL: begin
					// advance even for clipped pixels
					if (left_q != 8'd0) begin
						row_q  <= row_q + SCR_BITS'(1);
						left_q <= left_q - 8'd1;
					end
				end
			endcase
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/cpb_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpb_queue: request queue between front and back end
// Small circular buffer of requests; lets either side stall on its own.
// ----------------------------------------------------------------------------
module cpb_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  cpb_pkg::req_t       push_req,
	output logic                full,
	output logic                head_valid,
	output cpb_pkg::req_t       head_req,
	input  wire logic           pop
);
	import cpb_pkg::*;

	req_t                  slots_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wr_ptr_q;
	logic [QUEUE_AW-1:0]   rd_ptr_q;
	logic [QUEUE_AW:0]     count_q;

	assign full       = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_req   = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + (QUEUE_AW+1)'(1);
				2'b01:   count_q <= count_q - (QUEUE_AW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/cpb_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpb_back: palette store and pixel output
// Applies palette writes in request order, looks up the colour and forms
// the canvas address row * width + column over two registered stages.
// ----------------------------------------------------------------------------
module cpb_back (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     head_valid,
	input  cpb_pkg::req_t                 head_req,
	output logic                          pop,
	input  wire logic [cpb_pkg::DIM_BITS-1:0] canvas_width,
	cpb_pixel_if.source                   pixels
);
	import cpb_pkg::*;

	logic [COLOR_BITS-1:0]   palette_q [PALETTE_DEPTH];

	logic                    valid_s1;
	logic [COLOR_BITS-1:0]   rgb_s1;
	logic                    index_ok_s1;
	logic [2*DIM_BITS-1:0]   prod_s1;
	logic [DIM_BITS-1:0]     col_s1;

	logic                    out_valid_q;
	logic [ADDR_BITS-1:0]    out_addr_q;
	logic [COLOR_BITS-1:0]   out_rgb_q;

	logic                    advance;
	logic [2*DIM_BITS-1:0]   addr_sum;

	assign advance  = !out_valid_q || pixels.ready;
	assign pop      = head_valid && advance;
	assign addr_sum = prod_s1 + (2*DIM_BITS)'(col_s1);

	assign pixels.valid         = out_valid_q;
	assign pixels.pixel_address = out_addr_q;
	assign pixels.pixel_rgb     = out_rgb_q;

	// palette write and registered palette read
	always_ff @(posedge clk) begin
		if (pop) begin
			if (head_req.is_write) begin
				palette_q[head_req.index[PAL_AW-1:0]] <= head_req.rgb;
			end else begin
				rgb_s1 <= palette_q[head_req.index[PAL_AW-1:0]];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && !head_req.is_write) begin
			prod_s1     <= head_req.row * canvas_width;
			col_s1      <= head_req.col;
			index_ok_s1 <= head_req.index_ok;
		end
		if (advance) begin
			out_addr_q <= addr_sum[ADDR_BITS-1:0];
			out_rgb_q  <= index_ok_s1 ? rgb_s1 : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s1    <= pop && !head_req.is_write;
			out_valid_q <= valid_s1;
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/column_post_patch_blitter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// column_post_patch_blitter: draw a column-post patch onto a clipped canvas
// Feed palette loads, column starts, post headers (stop at the terminator,
// do not send it) and post pixels on the command channel; each pixel that
// lands inside the canvas comes out as a pixel address (row * width +
// column, low 24 bits) and its palette colour. Commands are taken one per
// cycle while the queue is not full; the front end decides clipping in the
// accepting cycle and queues palette writes and visible pixels in order
// into a four-entry queue. The back end pops one request per cycle while
// the output is not stalled, reads the palette and multiplies row by width
// in one stage and adds the column into the output register. Write
// configuration only while the block is idle.
// ----------------------------------------------------------------------------
module column_post_patch_blitter (
	input  wire logic   clk,
	input  wire logic   arst_n,
	cpb_cmd_if.sink     items,
	cpb_cfg_if.sink     cfg,
	cpb_pixel_if.source pixels
);
	import cpb_pkg::*;

	logic                queue_full;
	logic                push;
	req_t                push_req;
	logic                head_valid;
	req_t                head_req;
	logic                pop;
	logic [DIM_BITS-1:0] canvas_width;

	cpb_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.items        (items),
		.cfg          (cfg),
		.queue_full   (queue_full),
		.push         (push),
		.push_req     (push_req),
		.canvas_width (canvas_width)
	);

	cpb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_req   (push_req),
		.full       (queue_full),
		.head_valid (head_valid),
		.head_req   (head_req),
		.pop        (pop)
	);

	cpb_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_req     (head_req),
		.pop          (pop),
		.canvas_width (canvas_width),
		.pixels       (pixels)
	);

endmodule
`default_nettype wire
